// File: rtl/assert_macros.svh
// Assertion macros used by rcppm_back.
// Each macro expects a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that an expression holds on every clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that a condition implies a consequence on the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/rcppm_pkg.sv
// Shared types and constants for the PPM frame encoder.
// No dependencies; used by rcppm_front, rcppm_back and the top level.
package rcppm_pkg;

  localparam int NUM_CHANNELS  = 9;
  localparam int PAYLOAD_BYTES = 7;
  localparam int LEN_W         = $clog2(PAYLOAD_BYTES + 1);
  localparam int CNT_W         = $clog2(NUM_CHANNELS + 1);
  localparam int SUM_W         = $clog2(NUM_CHANNELS * 255 + 1);
  localparam int IQ_DEPTH      = 4;
  localparam int IQ_PTR_W      = $clog2(IQ_DEPTH);
  localparam int IQ_CNT_W      = $clog2(IQ_DEPTH + 1);

  localparam logic [CNT_W-1:0] SYNC_SLOT = CNT_W'(NUM_CHANNELS);

  // Command codes on the cmd field
  localparam logic CMD_PACKET = 1'b0;
  localparam logic CMD_TICK   = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_FRAME_PERIOD = 3'd0;
  localparam logic [2:0] REG_MIN_SYNC     = 3'd1;
  localparam logic [2:0] REG_BASE_WIDTH   = 3'd2;
  localparam logic [2:0] REG_GAP_WIDTH    = 3'd3;
  localparam logic [2:0] REG_CHAN_MIN     = 3'd4;
  localparam logic [2:0] REG_CHAN_MAX     = 3'd5;
  localparam logic [2:0] REG_TRIM_LIMIT   = 3'd6;
  localparam logic [2:0] REG_TRIM_REPEAT  = 3'd7;

  // Trim switch codes
  localparam logic [7:0] TRIM_NONE     = 8'd0;
  localparam logic [7:0] TRIM_ROLL_UP  = 8'd2;
  localparam logic [7:0] TRIM_ROLL_DN  = 8'd1;
  localparam logic [7:0] TRIM_PITCH_UP = 8'd6;
  localparam logic [7:0] TRIM_PITCH_DN = 8'd3;
  localparam logic [7:0] TRIM_YAW_UP   = 8'd18;
  localparam logic [7:0] TRIM_YAW_DN   = 8'd9;
  localparam logic [7:0] TRIM_THR_UP   = 8'd54;
  localparam logic [7:0] TRIM_THR_DN   = 8'd27;

  // Reset values
  localparam logic [7:0] CHAN_RESET [NUM_CHANNELS] =
    '{8'h06, 8'h7d, 8'h7d, 8'h7d, 8'h7d, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] PAY_RESET [PAYLOAD_BYTES] =
    '{8'h00, 8'h7d, 8'h7d, 8'h7d, 8'h7d, 8'h00, 8'h00};
  localparam logic signed [6:0] TRIM_RESET = -7'sd5;

  typedef struct packed {
    logic [15:0] frame_period;
    logic [15:0] min_sync;
    logic [9:0]  base_width;
    logic [9:0]  gap_width;
    logic [7:0]  chan_min;
    logic [7:0]  chan_max;
    logic [5:0]  trim_limit;
    logic [7:0]  trim_repeat;
  } cfg_t;

  // Classified item as it sits in the queue between front and back
  typedef struct packed {
    logic                             is_tick;
    logic [LEN_W-1:0]                 len;
    logic [PAYLOAD_BYTES-1:0][7:0]    bytes;
  } item_t;

  typedef struct packed {
    logic        level;
    logic [15:0] dur;
    logic        red;
    logic        green;
  } result_t;

endpackage

// File: rtl/rc_ppm_frame_encoder_core.sv
// Top level of the PPM frame encoder: configuration registers, front end
// and back end. Depends on rcppm_pkg, rcppm_front and rcppm_back.
//
// Usage:
//   Input channel: drive cmd and the payload fields with push high; the item
//   is taken on a clock edge where full is low. cmd low is a received packet
//   (payload_length above 7 drops it), cmd high is a timer tick.
//   Result channel: each tick yields one segment (line_level, duration_ticks,
//   led_red, led_green) shown while empty is low and taken when pop is high.
//   Packets yield no result.
//   An item is written into the item queue, executed from its head into the
//   result queue, and its result can be popped from there.
//   Throughput: one item per cycle while the result queue has room. A sync
//   pulse that directly follows a packet waits for the registered sum to update.
//   When the receiver stops popping, two results are held, then the next tick
//   waits at the head of the four-entry item queue and full rises once four
//   items wait; nothing behind that tick is executed until a result is popped.
//   Configuration: cfg_wr_en writes cfg_data into register cfg_addr at once;
//   write only while no item is in flight.
//   Reset (rst, synchronous): registers take their defaults, channels and
//   trims their power-up values, both queues empty.
module rc_ppm_frame_encoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic        cmd,
  input  logic [7:0]  payload_length,
  input  logic [7:0]  throttle_byte,
  input  logic [7:0]  roll_byte,
  input  logic [7:0]  pitch_byte,
  input  logic [7:0]  yaw_byte,
  input  logic [7:0]  knob_byte,
  input  logic [7:0]  switch_bits,
  input  logic [7:0]  trim_code,
  output logic        empty,
  input  logic        pop,
  output logic        line_level,
  output logic [15:0] duration_ticks,
  output logic        led_red,
  output logic        led_green,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_data
);

  rcppm_pkg::cfg_t    cfg;
  rcppm_pkg::item_t   head;
  rcppm_pkg::result_t res;
  logic               head_valid;
  logic               head_take;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_period <= 16'd5000;
      cfg.min_sync     <= 16'd1250;
      cfg.base_width   <= 10'd150;
      cfg.gap_width    <= 10'd100;
      cfg.chan_min     <= 8'd6;
      cfg.chan_max     <= 8'd244;
      cfg.trim_limit   <= 6'd50;
      cfg.trim_repeat  <= 8'd20;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        rcppm_pkg::REG_FRAME_PERIOD: cfg.frame_period <= cfg_data;
        rcppm_pkg::REG_MIN_SYNC:     cfg.min_sync     <= cfg_data;
        rcppm_pkg::REG_BASE_WIDTH:   cfg.base_width   <= cfg_data[9:0];
        rcppm_pkg::REG_GAP_WIDTH:    cfg.gap_width    <= cfg_data[9:0];
        rcppm_pkg::REG_CHAN_MIN:     cfg.chan_min     <= cfg_data[7:0];
        rcppm_pkg::REG_CHAN_MAX:     cfg.chan_max     <= cfg_data[7:0];
        rcppm_pkg::REG_TRIM_LIMIT:   cfg.trim_limit   <= cfg_data[5:0];
        rcppm_pkg::REG_TRIM_REPEAT:  cfg.trim_repeat  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  rcppm_front u_front (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .cmd            (cmd),
    .payload_length (payload_length),
    .throttle_byte  (throttle_byte),
    .roll_byte      (roll_byte),
    .pitch_byte     (pitch_byte),
    .yaw_byte       (yaw_byte),
    .knob_byte      (knob_byte),
    .switch_bits    (switch_bits),
    .trim_code      (trim_code),
    .head           (head),
    .head_valid     (head_valid),
    .head_take      (head_take)
  );

  rcppm_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head       (head),
    .head_valid (head_valid),
    .head_take  (head_take),
    .empty      (empty),
    .pop        (pop),
    .res        (res)
  );

  assign line_level     = res.level;
  assign duration_ticks = res.dur;
  assign led_red        = res.red;
  assign led_green      = res.green;

endmodule

// File: rtl/rcppm_front.sv
// Front end: accepts items, drops overlong packets, queues the rest.
// Depends on rcppm_pkg.
module rcppm_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  logic                 cmd,
  input  logic [7:0]           payload_length,
  input  logic [7:0]           throttle_byte,
  input  logic [7:0]           roll_byte,
  input  logic [7:0]           pitch_byte,
  input  logic [7:0]           yaw_byte,
  input  logic [7:0]           knob_byte,
  input  logic [7:0]           switch_bits,
  input  logic [7:0]           trim_code,
  output rcppm_pkg::item_t     head,
  output logic                 head_valid,
  input  logic                 head_take
);

  rcppm_pkg::item_t                     item_in;
  rcppm_pkg::item_t                     mem [rcppm_pkg::IQ_DEPTH];
  logic [rcppm_pkg::IQ_PTR_W-1:0]       wr_ptr;
  logic [rcppm_pkg::IQ_PTR_W-1:0]       rd_ptr;
  logic [rcppm_pkg::IQ_CNT_W-1:0]       count;
  logic                                 keep;
  logic                                 enq;
  logic                                 deq;

  // Classify: ticks always pass, packets only when they fit the payload
  always_comb begin
    keep = (cmd == rcppm_pkg::CMD_TICK) ||
           (payload_length <= 8'(rcppm_pkg::PAYLOAD_BYTES));
    item_in.is_tick  = (cmd == rcppm_pkg::CMD_TICK);
    item_in.len      = payload_length[rcppm_pkg::LEN_W-1:0];
    item_in.bytes[0] = throttle_byte;
    item_in.bytes[1] = roll_byte;
    item_in.bytes[2] = pitch_byte;
    item_in.bytes[3] = yaw_byte;
    item_in.bytes[4] = knob_byte;
    item_in.bytes[5] = switch_bits;
    item_in.bytes[6] = trim_code;
  end

  assign full       = (count == rcppm_pkg::IQ_CNT_W'(rcppm_pkg::IQ_DEPTH));
  assign enq        = push && !full && keep;
  assign head_valid = (count != '0);
  assign deq        = head_take && head_valid;
  assign head       = mem[rd_ptr];

  // Store queued items
  always_ff @(posedge clk) begin
    if (enq) begin
      mem[wr_ptr] <= item_in;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (enq) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (deq) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({enq, deq})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/rcppm_back.sv
// Back end: applies packets to trims and channel widths, turns ticks into
// PPM segments, and buffers results. Depends on rcppm_pkg, assert_macros.svh.
`include "assert_macros.svh"
module rcppm_back (
  input  logic                 clk,
  input  logic                 rst,
  input  rcppm_pkg::cfg_t      cfg,
  input  rcppm_pkg::item_t     head,
  input  logic                 head_valid,
  output logic                 head_take,
  output logic                 empty,
  input  logic                 pop,
  output rcppm_pkg::result_t   res
);

  logic [7:0]                      channel_store [rcppm_pkg::NUM_CHANNELS];
  logic [7:0]                      payload_store [rcppm_pkg::PAYLOAD_BYTES];
  logic [7:0]                      chan_next     [rcppm_pkg::NUM_CHANNELS];
  logic [7:0]                      pay_next      [rcppm_pkg::PAYLOAD_BYTES];
  logic signed [6:0]               trim_thr, trim_roll, trim_pitch, trim_yaw;
  logic signed [6:0]               trim_thr_next, trim_roll_next;
  logic signed [6:0]               trim_pitch_next, trim_yaw_next;
  logic [7:0]                      repeat_countdown, repeat_countdown_next;
  logic [rcppm_pkg::CNT_W-1:0]     channel_counter, channel_counter_next;
  logic                            gap_next, red_held, green_held;
  logic [rcppm_pkg::SUM_W-1:0]     chan_sum, chan_sum_next;
  logic                            sum_stale;
  logic                            step;
  logic                            need_sync;
  logic                            tick_ok;
  logic                            take_pkt, take_tick;
  logic [10:0]                     per_chan;
  logic [14:0]                     overhead;
  logic signed [17:0]              sync_raw;
  rcppm_pkg::result_t              res_new;
  rcppm_pkg::result_t              rq_mem [2];
  logic                            rq_wr, rq_rd;
  logic [1:0]                      rq_count;
  logic                            rq_push, rq_pop;

  function automatic logic signed [6:0] trim_inc(input logic signed [6:0] t,
                                                 input logic [5:0] lim);
    logic signed [7:0] t_w;
    t_w = $signed({t[6], t});
    if (t_w < $signed({2'b00, lim})) begin
      return t + 7'sd1;
    end
    return t;
  endfunction

  function automatic logic signed [6:0] trim_dec(input logic signed [6:0] t,
                                                 input logic [5:0] lim);
    logic signed [7:0] t_w;
    logic signed [7:0] neg;
    t_w = $signed({t[6], t});
    neg = -$signed({2'b00, lim});
    if (t_w > neg) begin
      return t - 7'sd1;
    end
    return t;
  endfunction

  // Upper bound is tested first, so with inverted bounds a value above chan_max gives chan_max, any other chan_min
  function automatic logic [7:0] clamp_chan(input logic signed [10:0] v,
                                            input logic [7:0] lo,
                                            input logic [7:0] hi);
    if (v > $signed({3'b000, hi})) begin
      return hi;
    end
    if (v < $signed({3'b000, lo})) begin
      return lo;
    end
    return v[7:0];
  endfunction

  // Merge packet bytes, step trims, recompute channels
  always_comb begin
    for (int i = 0; i < rcppm_pkg::PAYLOAD_BYTES; i++) begin
      pay_next[i] = (i < int'(head.len)) ? head.bytes[i] : payload_store[i];
    end
    step                  = 1'b0;
    repeat_countdown_next = 8'd0;
    if (pay_next[6] != rcppm_pkg::TRIM_NONE) begin
      if (repeat_countdown == 8'd0) begin
        step                  = 1'b1;
        repeat_countdown_next = cfg.trim_repeat;
      end else begin
        repeat_countdown_next = repeat_countdown - 8'd1;
      end
    end
    trim_thr_next   = trim_thr;
    trim_roll_next  = trim_roll;
    trim_pitch_next = trim_pitch;
    trim_yaw_next   = trim_yaw;
    if (step) begin
      unique case (pay_next[6])
        rcppm_pkg::TRIM_ROLL_UP:  trim_roll_next  = trim_inc(trim_roll, cfg.trim_limit);
        rcppm_pkg::TRIM_ROLL_DN:  trim_roll_next  = trim_dec(trim_roll, cfg.trim_limit);
        rcppm_pkg::TRIM_PITCH_UP: trim_pitch_next = trim_inc(trim_pitch, cfg.trim_limit);
        rcppm_pkg::TRIM_PITCH_DN: trim_pitch_next = trim_dec(trim_pitch, cfg.trim_limit);
        rcppm_pkg::TRIM_YAW_UP:   trim_yaw_next   = trim_inc(trim_yaw, cfg.trim_limit);
        rcppm_pkg::TRIM_YAW_DN:   trim_yaw_next   = trim_dec(trim_yaw, cfg.trim_limit);
        rcppm_pkg::TRIM_THR_UP:   trim_thr_next   = trim_inc(trim_thr, cfg.trim_limit);
        rcppm_pkg::TRIM_THR_DN:   trim_thr_next   = trim_dec(trim_thr, cfg.trim_limit);
        default: ;
      endcase
    end
    chan_next[0] = clamp_chan(11'sd255 - $signed({3'b000, pay_next[0]})
                              - $signed({{4{trim_thr_next[6]}}, trim_thr_next}),
                              cfg.chan_min, cfg.chan_max);
    chan_next[1] = clamp_chan($signed({3'b000, pay_next[1]})
                              - $signed({{4{trim_roll_next[6]}}, trim_roll_next}),
                              cfg.chan_min, cfg.chan_max);
    chan_next[2] = clamp_chan(11'sd255 - $signed({3'b000, pay_next[2]})
                              - $signed({{4{trim_pitch_next[6]}}, trim_pitch_next}),
                              cfg.chan_min, cfg.chan_max);
    chan_next[3] = clamp_chan($signed({3'b000, pay_next[3]})
                              - $signed({{4{trim_yaw_next[6]}}, trim_yaw_next}),
                              cfg.chan_min, cfg.chan_max);
    chan_next[4] = clamp_chan($signed({3'b000, pay_next[4]}),
                              cfg.chan_min, cfg.chan_max);
    for (int i = 0; i < 4; i++) begin
      chan_next[5 + i] = pay_next[5][i] ? cfg.chan_max : cfg.chan_min;
    end
  end

  // Sum of stored channel widths, registered into chan_sum after the store
  always_comb begin
    chan_sum_next = '0;
    for (int i = 0; i < rcppm_pkg::NUM_CHANNELS; i++) begin
      chan_sum_next = chan_sum_next + rcppm_pkg::SUM_W'(channel_store[i]);
    end
  end

  // Build the next segment for a tick
  always_comb begin
    need_sync = !gap_next && (channel_counter >= rcppm_pkg::SYNC_SLOT);
    per_chan  = {1'b0, cfg.base_width} + {1'b0, cfg.gap_width};
    overhead  = 15'({per_chan, 3'b000}) + 15'(per_chan) + 15'(chan_sum);
    sync_raw  = $signed({2'b00, cfg.frame_period}) - $signed({3'b000, overhead});
    channel_counter_next = channel_counter;
    res_new.red   = red_held;
    res_new.green = green_held;
    if (gap_next) begin
      res_new.level = 1'b0;
      res_new.dur   = 16'(cfg.gap_width);
      res_new.red   = (channel_counter == rcppm_pkg::CNT_W'(3));
      res_new.green = (channel_counter == '0);
    end else if (need_sync) begin
      res_new.level = 1'b1;
      res_new.dur   = (sync_raw < $signed({2'b00, cfg.min_sync})) ?
                      cfg.min_sync : sync_raw[15:0];
      channel_counter_next = '0;
    end else begin
      res_new.level = 1'b1;
      res_new.dur   = 16'(channel_store[channel_counter]) + 16'(cfg.base_width);
      channel_counter_next = channel_counter + 1'b1;
    end
  end

  // Stall a tick on a full result queue or a sync that needs a fresh sum
  assign tick_ok   = (rq_count < 2'd2) && !(need_sync && sum_stale);
  assign head_take = head_valid && (!head.is_tick || tick_ok);
  assign take_pkt  = head_take && !head.is_tick;
  assign take_tick = head_take && head.is_tick;
  assign rq_push   = take_tick;
  assign empty     = (rq_count == 2'd0);
  assign rq_pop    = pop && !empty;
  assign res       = rq_mem[rq_rd];

  // Hold channel, payload and trim state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < rcppm_pkg::NUM_CHANNELS; i++) begin
        channel_store[i] <= rcppm_pkg::CHAN_RESET[i];
      end
      for (int i = 0; i < rcppm_pkg::PAYLOAD_BYTES; i++) begin
        payload_store[i] <= rcppm_pkg::PAY_RESET[i];
      end
      trim_thr         <= rcppm_pkg::TRIM_RESET;
      trim_roll        <= rcppm_pkg::TRIM_RESET;
      trim_pitch       <= rcppm_pkg::TRIM_RESET;
      trim_yaw         <= rcppm_pkg::TRIM_RESET;
      repeat_countdown <= 8'd0;
      chan_sum         <= '0;
      sum_stale        <= 1'b1;
    end else begin
      chan_sum  <= chan_sum_next;
      sum_stale <= take_pkt;
      if (take_pkt) begin
        channel_store    <= chan_next;
        payload_store    <= pay_next;
        trim_thr         <= trim_thr_next;
        trim_roll        <= trim_roll_next;
        trim_pitch       <= trim_pitch_next;
        trim_yaw         <= trim_yaw_next;
        repeat_countdown <= repeat_countdown_next;
      end
    end
  end

  // Advance segment state on each tick
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_counter <= '0;
      gap_next        <= 1'b0;
      red_held        <= 1'b0;
      green_held      <= 1'b0;
    end else if (take_tick) begin
      channel_counter <= channel_counter_next;
      gap_next        <= !gap_next;
      red_held        <= res_new.red;
      green_held      <= res_new.green;
    end
  end

  // Result queue storage
  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq_mem[rq_wr] <= res_new;
    end
  end

  // Result queue pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr    <= 1'b0;
      rq_rd    <= 1'b0;
      rq_count <= 2'd0;
    end else begin
      if (rq_push) begin
        rq_wr <= !rq_wr;
      end
      if (rq_pop) begin
        rq_rd <= !rq_rd;
      end
      case ({rq_push, rq_pop})
        2'b10:   rq_count <= rq_count + 2'd1;
        2'b01:   rq_count <= rq_count - 2'd1;
        default: rq_count <= rq_count;
      endcase
    end
  end

  `ASSERT_ALWAYS(a_rq_bound, rq_count <= 2'd2, "result queue overflow")
  `ASSERT_ALWAYS(a_cnt_bound, channel_counter <= rcppm_pkg::SYNC_SLOT, "channel counter past sync")
  `ASSERT_IMPLIES(a_sync_fresh, take_tick && need_sync, !sum_stale, "sync used a stale sum")
  `ASSERT_NEXT(a_sync_wrap, take_tick && need_sync, channel_counter == '0, "counter not wrapped")

endmodule

// File: dv/tb_rc_ppm_frame_encoder_core.sv
// Self-checking testbench for rc_ppm_frame_encoder_core: directed rows, then random
// packets and ticks over several register settings, checked against a local predictor.
// Depends on rcppm_pkg and the RTL of the encoder core.
module tb_rc_ppm_frame_encoder_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT     = 500000;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int NUM_PHASES      = 6;
  localparam int DRAIN_CYCLES    = 8;
  localparam int NUM_ROWS        = 26;

  // Trim axes, in the order of the trim store
  localparam int AX_THR   = 0;
  localparam int AX_ROLL  = 1;
  localparam int AX_PITCH = 2;
  localparam int AX_YAW   = 3;

  localparam logic [7:0] TRIM_CODES [8] = '{rcppm_pkg::TRIM_ROLL_UP,
    rcppm_pkg::TRIM_ROLL_DN, rcppm_pkg::TRIM_PITCH_UP, rcppm_pkg::TRIM_PITCH_DN,
    rcppm_pkg::TRIM_YAW_UP, rcppm_pkg::TRIM_YAW_DN, rcppm_pkg::TRIM_THR_UP,
    rcppm_pkg::TRIM_THR_DN};

  localparam rcppm_pkg::cfg_t CFG_DEFAULT = '{frame_period: 16'd5000, min_sync: 16'd1250,
    base_width: 10'd150, gap_width: 10'd100, chan_min: 8'd6, chan_max: 8'd244,
    trim_limit: 6'd50, trim_repeat: 8'd20};

  // One input item; bytes[0] is throttle, bytes[6] the trim code
  typedef struct packed {
    logic            cmd;
    logic [7:0]      len;
    logic [6:0][7:0] bytes;
  } stim_t;

  typedef struct packed {
    stim_t              it;
    logic               typed;
    rcppm_pkg::result_t seg;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        push = 1'b0;
  logic        full;
  logic        cmd = rcppm_pkg::CMD_PACKET;
  logic [7:0]  payload_length = 8'd0;
  logic [7:0]  throttle_byte = 8'd0;
  logic [7:0]  roll_byte = 8'd0;
  logic [7:0]  pitch_byte = 8'd0;
  logic [7:0]  yaw_byte = 8'd0;
  logic [7:0]  knob_byte = 8'd0;
  logic [7:0]  switch_bits = 8'd0;
  logic [7:0]  trim_code = 8'd0;
  logic        empty;
  logic        pop = 1'b0;
  logic        line_level;
  logic [15:0] duration_ticks;
  logic        led_red;
  logic        led_green;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_addr = 3'd0;
  logic [15:0] cfg_data = 16'd0;

  rc_ppm_frame_encoder_core dut (
    .clk, .rst, .push, .full, .cmd, .payload_length, .throttle_byte, .roll_byte,
    .pitch_byte, .yaw_byte, .knob_byte, .switch_bits, .trim_code, .empty, .pop,
    .line_level, .duration_ticks, .led_red, .led_green, .cfg_wr_en, .cfg_addr, .cfg_data
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 0;
  end

  // Predictor state
  rcppm_pkg::cfg_t   cfg_now = CFG_DEFAULT;
  logic [7:0]        chan_w [rcppm_pkg::NUM_CHANNELS] = rcppm_pkg::CHAN_RESET;
  logic [7:0]        pay_mem [rcppm_pkg::PAYLOAD_BYTES] = rcppm_pkg::PAY_RESET;
  logic signed [6:0] trim_val [4] = '{rcppm_pkg::TRIM_RESET, rcppm_pkg::TRIM_RESET,
                                      rcppm_pkg::TRIM_RESET, rcppm_pkg::TRIM_RESET};
  logic [7:0]        repeat_left = 8'd0;
  int                slot = 0;
  bit                gap_pending = 1'b0;
  bit                red_led = 1'b0;
  bit                green_led = 1'b0;

  rcppm_pkg::result_t expected_segments [$];
  int      fails = 0;
  int      cycles = 0;
  int      accepted_items = 0;
  int      checked_segments = 0;
  int      settings_written = 0;
  int      burst_tx = 0;
  logic [7:0] held_code = rcppm_pkg::TRIM_NONE;

  function automatic logic [7:0] clamp_width(int v);
    if (v > int'(cfg_now.chan_max)) return cfg_now.chan_max;
    if (v < int'(cfg_now.chan_min)) return cfg_now.chan_min;
    return v[7:0];
  endfunction

  task automatic nudge_trim(int axis, bit up);
    if (up) begin
      if (int'(trim_val[axis]) < int'(cfg_now.trim_limit)) trim_val[axis] = trim_val[axis] + 7'sd1;
    end else if (int'(trim_val[axis]) > -int'(cfg_now.trim_limit)) begin
      trim_val[axis] = trim_val[axis] - 7'sd1;
    end
  endtask

  // Ignore an overlong packet; else store its bytes, step the trims and rebuild all channel widths
  task automatic apply_packet(stim_t it);
    int i;
    if (it.len > rcppm_pkg::PAYLOAD_BYTES) return;
    for (i = 0; i < int'(it.len); i++) pay_mem[i] = it.bytes[i];
    if (pay_mem[6] != rcppm_pkg::TRIM_NONE) begin
      if (repeat_left == 8'd0) begin
        repeat_left = cfg_now.trim_repeat;
        case (pay_mem[6])
          rcppm_pkg::TRIM_ROLL_UP:  nudge_trim(AX_ROLL, 1'b1);
          rcppm_pkg::TRIM_ROLL_DN:  nudge_trim(AX_ROLL, 1'b0);
          rcppm_pkg::TRIM_PITCH_UP: nudge_trim(AX_PITCH, 1'b1);
          rcppm_pkg::TRIM_PITCH_DN: nudge_trim(AX_PITCH, 1'b0);
          rcppm_pkg::TRIM_YAW_UP:   nudge_trim(AX_YAW, 1'b1);
          rcppm_pkg::TRIM_YAW_DN:   nudge_trim(AX_YAW, 1'b0);
          rcppm_pkg::TRIM_THR_UP:   nudge_trim(AX_THR, 1'b1);
          rcppm_pkg::TRIM_THR_DN:   nudge_trim(AX_THR, 1'b0);
          default: ;
        endcase
      end else begin
        repeat_left = repeat_left - 8'd1;
      end
    end else begin
      repeat_left = 8'd0;
    end
    chan_w[0] = clamp_width(255 - int'(pay_mem[0]) - int'(trim_val[AX_THR]));
    chan_w[1] = clamp_width(int'(pay_mem[1]) - int'(trim_val[AX_ROLL]));
    chan_w[2] = clamp_width(255 - int'(pay_mem[2]) - int'(trim_val[AX_PITCH]));
    chan_w[3] = clamp_width(int'(pay_mem[3]) - int'(trim_val[AX_YAW]));
    chan_w[4] = clamp_width(int'(pay_mem[4]));
    for (i = 0; i < 4; i++) chan_w[5 + i] = pay_mem[5][i] ? cfg_now.chan_max : cfg_now.chan_min;
  endtask

  // Produce the next segment of the pulse train: pulse, gap or sync
  task automatic predict_segment(output rcppm_pkg::result_t seg);
    int acc;
    int i;
    if (gap_pending) begin
      gap_pending = 1'b0;
      seg.level = 1'b0;
      seg.dur = 16'(cfg_now.gap_width);
      red_led = (slot == 3);
      green_led = (slot == 0);
    end else begin
      gap_pending = 1'b1;
      seg.level = 1'b1;
      if (slot >= rcppm_pkg::NUM_CHANNELS) begin
        acc = int'(cfg_now.frame_period);
        for (i = 0; i < rcppm_pkg::NUM_CHANNELS; i++)
          acc -= int'(chan_w[i]) + int'(cfg_now.base_width) + int'(cfg_now.gap_width);
        if (acc < int'(cfg_now.min_sync)) acc = int'(cfg_now.min_sync);
        seg.dur = acc[15:0];
        slot = 0;
      end else begin
        seg.dur = 16'(chan_w[slot]) + 16'(cfg_now.base_width);
        slot++;
      end
    end
    seg.red = red_led;
    seg.green = green_led;
  endtask

  // Offer one item after a random gap, hold it until taken, then predict
  task automatic send_item(stim_t it, logic typed, rcppm_pkg::result_t typed_seg);
    int gap;
    rcppm_pkg::result_t seg;
    if (burst_tx > 0) begin
      gap = 0;
      burst_tx--;
    end else begin
      gap = $urandom_range(0, 11);
      if ($urandom_range(0, 24) == 0) burst_tx = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push <= 1'b1;
    cmd <= it.cmd;
    payload_length <= it.len;
    throttle_byte <= it.bytes[0];
    roll_byte <= it.bytes[1];
    pitch_byte <= it.bytes[2];
    yaw_byte <= it.bytes[3];
    knob_byte <= it.bytes[4];
    switch_bits <= it.bytes[5];
    trim_code <= it.bytes[6];
    do @(posedge clk); while (full);
    accepted_items++;
    if (it.cmd == rcppm_pkg::CMD_TICK) begin
      predict_segment(seg);
      expected_segments.push_back(typed ? typed_seg : seg);
    end else begin
      apply_packet(it);
    end
  endtask

  // Drain the block, then write every register in one burst
  task automatic program_regs(rcppm_pkg::cfg_t c);
    int r;
    push <= 1'b0;
    while (expected_segments.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    for (r = 0; r < 8; r++) begin
      cfg_wr_en <= 1'b1;
      cfg_addr <= 3'(r);
      case (3'(r))
        rcppm_pkg::REG_FRAME_PERIOD: cfg_data <= c.frame_period;
        rcppm_pkg::REG_MIN_SYNC:     cfg_data <= c.min_sync;
        rcppm_pkg::REG_BASE_WIDTH:   cfg_data <= 16'(c.base_width);
        rcppm_pkg::REG_GAP_WIDTH:    cfg_data <= 16'(c.gap_width);
        rcppm_pkg::REG_CHAN_MIN:     cfg_data <= 16'(c.chan_min);
        rcppm_pkg::REG_CHAN_MAX:     cfg_data <= 16'(c.chan_max);
        rcppm_pkg::REG_TRIM_LIMIT:   cfg_data <= 16'(c.trim_limit);
        default:                     cfg_data <= 16'(c.trim_repeat);
      endcase
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
    cfg_now = c;
    settings_written++;
  endtask

  function automatic stim_t random_item();
    stim_t it;
    int r;
    int i;
    it.cmd = ($urandom_range(0, 99) < 45) ? rcppm_pkg::CMD_TICK : rcppm_pkg::CMD_PACKET;
    r = $urandom_range(0, 99);
    if (r < 70) it.len = 8'd7;
    else if (r < 85) it.len = 8'($urandom_range(0, 7));
    else it.len = 8'($urandom_range(8, 255));
    for (i = 0; i < 6; i++) begin
      r = $urandom_range(0, 9);
      it.bytes[i] = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom());
    end
    // Hold a trim code over several packets so auto-repeat gets exercised
    if ($urandom_range(0, 7) == 0) begin
      r = $urandom_range(0, 9);
      if (r < 6) held_code = TRIM_CODES[$urandom_range(0, 7)];
      else if (r < 8) held_code = rcppm_pkg::TRIM_NONE;
      else held_code = 8'($urandom());
    end
    it.bytes[6] = held_code;
    return it;
  endfunction

  function automatic dir_row_t tick_row(logic typed, logic lvl, int dur, logic r, logic g);
    dir_row_t row;
    row.it = '{cmd: rcppm_pkg::CMD_TICK, len: 8'd0, bytes: '0};
    row.typed = typed;
    row.seg = '{level: lvl, dur: 16'(dur), red: r, green: g};
    return row;
  endfunction

  // Bytes are given trim code first, throttle last
  function automatic dir_row_t packet_row(logic [7:0] len, logic [55:0] b);
    dir_row_t row;
    row.it = '{cmd: rcppm_pkg::CMD_PACKET, len: len, bytes: b};
    row.typed = 1'b0;
    row.seg = '0;
    return row;
  endfunction

  // Check each result against the oldest expected segment
  initial begin
    int stall;
    int burst_rx;
    rcppm_pkg::result_t want;
    burst_rx = 0;
    wait (!rst);
    forever begin
      if (burst_rx > 0) begin
        stall = 0;
        burst_rx--;
      end else begin
        stall = $urandom_range(0, 11);
        if ($urandom_range(0, 24) == 0) burst_rx = $urandom_range(10, 40);
      end
      if (stall > 0) begin
        pop <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      if (expected_segments.size() == 0) begin
        $error("segment with none expected: level %0d dur %0d", line_level, duration_ticks);
        fails++;
      end else begin
        want = expected_segments.pop_front();
        checked_segments++;
        if (line_level !== want.level) begin
          $error("line_level expected %0d got %0d", want.level, line_level);
          fails++;
        end
        if (duration_ticks !== want.dur) begin
          $error("duration_ticks expected %0d got %0d", want.dur, duration_ticks);
          fails++;
        end
        if (led_red !== want.red) begin
          $error("led_red expected %0d got %0d", want.red, led_red);
          fails++;
        end
        if (led_green !== want.green) begin
          $error("led_green expected %0d got %0d", want.green, led_green);
          fails++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    dir_row_t plan [NUM_ROWS];
    rcppm_pkg::cfg_t c;
    stim_t it;
    int i;
    int phase;
    int counted;
    int random_items;
    random_items = 0;
    // Pulses and gaps after reset, red lit after the third channel
    plan = '{
      tick_row(1'b1, 1'b1, 156, 1'b0, 1'b0),
      tick_row(1'b1, 1'b0, 100, 1'b0, 1'b0),
      tick_row(1'b1, 1'b1, 275, 1'b0, 1'b0),
      tick_row(1'b1, 1'b0, 100, 1'b0, 1'b0),
      tick_row(1'b1, 1'b1, 275, 1'b0, 1'b0),
      tick_row(1'b1, 1'b0, 100, 1'b1, 1'b0),
      tick_row(1'b1, 1'b1, 275, 1'b1, 1'b0),
      tick_row(1'b1, 1'b0, 100, 1'b0, 1'b0),
      packet_row(8'd8, 56'hFF_FF_FF_FF_FF_FF_FF),
      packet_row(8'd0, 56'h36_FF_FF_FF_FF_FF_FF),
      packet_row(8'd7, {rcppm_pkg::TRIM_THR_UP, 48'hFF_FF_FF_FF_FF_FF}),
      packet_row(8'd7, {rcppm_pkg::TRIM_NONE, 48'h00_00_00_00_00_00}),
      packet_row(8'd3, 56'h12_34_56_78_80_81_82),
      packet_row(8'd7, 56'hC3_0A_FE_01_80_7F_01),
      tick_row(1'b0, 1'b0, 0, 1'b0, 1'b0),
      tick_row(1'b0, 1'b0, 0, 1'b0, 1'b0),
      tick_row(1'b0, 1'b0, 0, 1'b0, 1'b0),
      tick_row(1'b0, 1'b0, 0, 1'b0, 1'b0),
      tick_row(1'b0, 1'b0, 0, 1'b0, 1'b0),
      tick_row(1'b0, 1'b0, 0, 1'b0, 1'b0),
      tick_row(1'b0, 1'b0, 0, 1'b0, 1'b0),
      tick_row(1'b0, 1'b0, 0, 1'b0, 1'b0),
      tick_row(1'b0, 1'b0, 0, 1'b0, 1'b0),
      tick_row(1'b0, 1'b0, 0, 1'b0, 1'b0),
      tick_row(1'b0, 1'b0, 0, 1'b0, 1'b0),
      tick_row(1'b0, 1'b0, 0, 1'b0, 1'b0)
    };
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed rows at reset settings
    for (i = 0; i < NUM_ROWS; i++) send_item(plan[i].it, plan[i].typed, plan[i].seg);

    // Random phases, each under its own register setting
    for (phase = 0; phase < NUM_PHASES; phase++) begin
      c.frame_period = 16'($urandom_range(0, 65535));
      c.min_sync = 16'($urandom_range(0, 4000));
      c.base_width = 10'($urandom_range(0, 1023));
      c.gap_width = 10'($urandom_range(0, 1023));
      c.chan_min = 8'($urandom_range(0, 60));
      c.chan_max = 8'($urandom_range(180, 255));
      c.trim_limit = 6'($urandom_range(0, 63));
      c.trim_repeat = 8'($urandom_range(0, 3));
      case (phase)
        1: c = '{frame_period: 16'hFFFF, min_sync: 16'hFFFF, base_width: 10'h3FF,
                 gap_width: 10'h3FF, chan_min: 8'hFF, chan_max: 8'hFF,
                 trim_limit: 6'h3F, trim_repeat: 8'hFF};
        2: c = '0;
        3: begin
          // Inverted bounds: values above chan_max give chan_max, the rest chan_min
          c.chan_min = 8'($urandom_range(129, 255));
          c.chan_max = 8'($urandom_range(0, 127));
        end
        5: c = CFG_DEFAULT;
        default: ;
      endcase
      program_regs(c);
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        it = random_item();
        send_item(it, 1'b0, '0);
        counted++;
        random_items++;
      end
    end

    // Let the last results come out
    push <= 1'b0;
    while (expected_segments.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES + 4) @(posedge clk);
    $display("summary: %0d items accepted (%0d random), %0d segments checked",
             accepted_items, random_items, checked_segments);
    $display("summary: %0d register settings, %0d mismatches", settings_written, fails);
    if (fails == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
